/* design/mexp_pkg.sv */
// ----------------------------------------------------------------------------
// mexp_pkg: shared types for the modular exponentiation block
// Operand widths, the multiply operand select and the command and status
// groups passed between the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package mexp_pkg;

  // Operand width of base, exponent, modulus and result
  localparam int WIDTH = 31;
  // Bit counter width for one pass of the shift-add unit
  localparam int CNT_W = $clog2(WIDTH);

  typedef logic [WIDTH-1:0] word_t;
  typedef logic [WIDTH:0]   wide_t;
  typedef logic [CNT_W-1:0] cnt_t;

  // Operand select for one modular multiplication
  typedef enum logic [1:0] {
    OP_REDUCE = 2'd0,  // 1 * base mod m: first reduction of the base
    OP_ACC    = 2'd1,  // acc * base mod m
    OP_SQUARE = 2'd2   // base * base mod m, then shift the exponent
  } op_sel_t;

  // Controller to datapath
  typedef struct packed {
    logic    load;       // capture a new request
    logic    mul_start;  // start one modular multiplication
    op_sel_t op;         // which operands and which register to update
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic mod_zero;  // captured modulus is zero
    logic exp_zero;  // remaining exponent is zero
    logic exp_lsb;   // low bit of the remaining exponent
    logic mul_done;  // last step of the running multiplication
  } status_t;

endpackage

`default_nettype wire

/* design/mexp_datapath.sv */
// ----------------------------------------------------------------------------
// mexp_datapath: operand registers and shift-add modular multiplier
// Holds modulus, remaining exponent, running base and accumulator, and
// forms (a * b) mod m one multiplier bit per cycle, MSB first.
// ----------------------------------------------------------------------------
`default_nettype none

module mexp_datapath (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire mexp_pkg::cmd_t    cmd,
  output mexp_pkg::status_t      status,
  input  wire mexp_pkg::word_t   base_value,
  input  wire mexp_pkg::word_t   exponent,
  input  wire mexp_pkg::word_t   modulus,
  output mexp_pkg::word_t        result
);

  mexp_pkg::word_t   mod_r;
  mexp_pkg::word_t   exp_r;
  mexp_pkg::word_t   base_r;
  mexp_pkg::word_t   acc_r;

  // Multiplier registers
  mexp_pkg::word_t   pa;      // multiplicand, below or equal to the modulus
  mexp_pkg::word_t   pb;      // multiplier bits, consumed from the top
  mexp_pkg::word_t   pacc;    // partial product, kept below the modulus
  mexp_pkg::cnt_t    cnt;
  logic              busy;
  mexp_pkg::op_sel_t op_r;

  mexp_pkg::wide_t   dbl;
  mexp_pkg::wide_t   dbl_sub;
  mexp_pkg::word_t   red1;
  mexp_pkg::word_t   addend;
  mexp_pkg::wide_t   sum;
  mexp_pkg::wide_t   sum_sub;
  mexp_pkg::word_t   red2;
  logic              last_step;

  // Double and reduce, then add the multiplicand when the top multiplier bit is set and reduce
  always_comb begin
    dbl     = {pacc, 1'b0};
    dbl_sub = dbl - {1'b0, mod_r};
    red1    = (dbl >= {1'b0, mod_r}) ? dbl_sub[mexp_pkg::WIDTH-1:0]
                                     : dbl[mexp_pkg::WIDTH-1:0];
    addend  = pb[mexp_pkg::WIDTH-1] ? pa : '0;
    sum     = {1'b0, red1} + {1'b0, addend};
    sum_sub = sum - {1'b0, mod_r};
    red2    = (sum >= {1'b0, mod_r}) ? sum_sub[mexp_pkg::WIDTH-1:0]
                                     : sum[mexp_pkg::WIDTH-1:0];
  end

  assign last_step = busy && (cnt == '0);

  // Multiplier control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (cmd.mul_start) begin
      busy <= 1'b1;
    end else if (last_step) begin
      busy <= 1'b0;
    end
  end

  // Operand loading, stepping and write-back
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mod_r  <= modulus;
      exp_r  <= exponent;
      base_r <= base_value;
      acc_r  <= (modulus == '0) ? '0 : mexp_pkg::word_t'(1);
    end else if (cmd.mul_start) begin
      pacc <= '0;
      cnt  <= mexp_pkg::cnt_t'(mexp_pkg::WIDTH - 1);
      op_r <= cmd.op;
      case (cmd.op)
        mexp_pkg::OP_REDUCE: begin
          pa <= mexp_pkg::word_t'(1);
          pb <= base_r;
        end
        mexp_pkg::OP_ACC: begin
          pa <= acc_r;
          pb <= base_r;
        end
        mexp_pkg::OP_SQUARE: begin
          pa <= base_r;
          pb <= base_r;
        end
        default: begin
          pa <= '0;
          pb <= '0;
        end
      endcase
    end else if (busy) begin
      pacc <= red2;
      pb   <= {pb[mexp_pkg::WIDTH-2:0], 1'b0};
      cnt  <= cnt - mexp_pkg::cnt_t'(1);
      if (last_step) begin
        case (op_r)
          mexp_pkg::OP_REDUCE: base_r <= red2;
          mexp_pkg::OP_ACC:    acc_r  <= red2;
          mexp_pkg::OP_SQUARE: begin
            base_r <= red2;
            exp_r  <= {1'b0, exp_r[mexp_pkg::WIDTH-1:1]};
          end
          default: ;
        endcase
      end
    end
  end

  assign status.mod_zero = (mod_r == '0);
  assign status.exp_zero = (exp_r == '0);
  assign status.exp_lsb  = exp_r[0];
  assign status.mul_done = last_step;
  assign result          = acc_r;

endmodule

`default_nettype wire

/* design/mexp_ctrl.sv */
// ----------------------------------------------------------------------------
// mexp_ctrl: sequencer for square-and-multiply
// Walks the exponent LSB first, issuing one multiply for each set bit and
// one square for every bit up to the highest set bit, and holds the result until it is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module mexp_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output mexp_pkg::cmd_t          cmd,
  input  wire mexp_pkg::status_t  status
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_START,
    S_REDUCE,
    S_CHECK,
    S_MUL_ACC,
    S_SQ_ISSUE,
    S_SQUARE,
    S_DONE
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_valid_next;

  assign in_stall = (state != S_IDLE);

  // Next state and commands
  always_comb begin
    state_next     = state;
    out_valid_next = out_valid;
    cmd.load       = 1'b0;
    cmd.mul_start  = 1'b0;
    cmd.op         = mexp_pkg::OP_REDUCE;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_START;
        end
      end
      S_START: begin
        // Zero modulus: no reduction, the result is zero
        if (status.mod_zero) begin
          state_next     = S_DONE;
          out_valid_next = 1'b1;
        end else begin
          cmd.mul_start = 1'b1;
          cmd.op        = mexp_pkg::OP_REDUCE;
          state_next    = S_REDUCE;
        end
      end
      S_REDUCE: begin
        if (status.mul_done) begin
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (status.exp_zero) begin
          state_next     = S_DONE;
          out_valid_next = 1'b1;
        end else if (status.exp_lsb) begin
          cmd.mul_start = 1'b1;
          cmd.op        = mexp_pkg::OP_ACC;
          state_next    = S_MUL_ACC;
        end else begin
          cmd.mul_start = 1'b1;
          cmd.op        = mexp_pkg::OP_SQUARE;
          state_next    = S_SQUARE;
        end
      end
      S_MUL_ACC: begin
        if (status.mul_done) begin
          state_next = S_SQ_ISSUE;
        end
      end
      S_SQ_ISSUE: begin
        cmd.mul_start = 1'b1;
        cmd.op        = mexp_pkg::OP_SQUARE;
        state_next    = S_SQUARE;
      end
      S_SQUARE: begin
        if (status.mul_done) begin
          state_next = S_CHECK;
        end
      end
      S_DONE: begin
        // Hold the result until the receiver takes it
        if (!out_stall) begin
          state_next     = S_IDLE;
          out_valid_next = 1'b0;
        end
      end
      default: begin
        state_next     = S_IDLE;
        out_valid_next = 1'b0;
      end
    endcase
  end

  // State and registered output
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

`default_nettype wire

/* design/modular_exponentiation.sv */
// ----------------------------------------------------------------------------
// modular_exponentiation: base ** exponent mod modulus
// Right-to-left binary square-and-multiply over a shift-add modular
// multiplier; a zero exponent gives 1 for any nonzero modulus.
// ----------------------------------------------------------------------------
//
//   channel   signals                                   direction
//   request   in_valid, in_stall, base_value, exponent,   in
//             modulus
//   result    out_valid, out_stall, result               out
//
// One request at a time. Each modular multiplication is an issue step, then
// WIDTH shift-add steps, one multiplier bit per cycle. A request runs the
// base reduction, then for each exponent bit up to its highest set bit a
// multiply into the accumulator when the bit is set followed by a square,
// and one last check before out_valid. Once an unstalled result has left,
// the next request can be taken in the cycle after.
// Reset is synchronous and clears the controller and the multiplier busy flag.
// A stalled result is held in the accumulator; no new request is taken until
// it leaves.
// ----------------------------------------------------------------------------
`default_nettype none

module modular_exponentiation (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  output logic                 in_stall,
  input  wire mexp_pkg::word_t base_value,
  input  wire mexp_pkg::word_t exponent,
  input  wire mexp_pkg::word_t modulus,
  output logic                 out_valid,
  input  wire logic            out_stall,
  output mexp_pkg::word_t      result
);

  mexp_pkg::cmd_t    cmd;
  mexp_pkg::status_t status;

  mexp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .status    (status)
  );

  mexp_datapath u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .status     (status),
    .base_value (base_value),
    .exponent   (exponent),
    .modulus    (modulus),
    .result     (result)
  );

  // A waiting result blocks new requests
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall)
    else $error("request taken while a result is pending");

  // An accepted request is never answered in the next cycle
  assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> !out_valid)
    else $error("result shown right after request");

  // Zero modulus answers zero, going from the start state straight to done
  assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && (modulus == '0)) |=> ##1 (out_valid && (result == '0)))
    else $error("zero modulus not answered with zero");

  // No multiply runs while a result is on the output
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (!cmd.mul_start && !status.mul_done))
    else $error("multiplier active while result pending");

endmodule

`default_nettype wire
